/* design/cbm_pkg.sv */
// shared types and constants for the cartridge bank mapper with clock
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package cbm_pkg;

  // sizes
  localparam int RAM_BANK_TOTAL = 4;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int ROM_BANK_TOTAL = 128;
  localparam int RAM_DEPTH      = RAM_BANK_TOTAL * RAM_BANK_BYTES;
  localparam int RAM_ADDR_W     = $clog2(RAM_DEPTH);
  localparam int RAM_OFFS_W     = $clog2(RAM_BANK_BYTES);
  localparam int RAM_SEL_W      = (RAM_BANK_TOTAL > 1) ? $clog2(RAM_BANK_TOTAL) : 1;
  localparam int CNT_W          = 3;
  localparam int ROM_BANK_W     = 7;
  localparam int ROM_OFFS_W     = 14;
  localparam int ROM_ADDR_W     = 21;

  // request codes
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // bank / clock select codes
  localparam logic [7:0] SEL_RAM_LAST = 8'h03;
  localparam logic [7:0] SEL_SEC      = 8'h08;
  localparam logic [7:0] SEL_MIN      = 8'h09;
  localparam logic [7:0] SEL_HOUR     = 8'h0A;
  localparam logic [7:0] SEL_DAY_LO   = 8'h0B;
  localparam logic [7:0] SEL_DAY_HI   = 8'h0C;

  // control write values
  localparam logic [7:0] RAM_ENABLE_KEY  = 8'h0A;
  localparam logic [7:0] RAM_DISABLE_KEY = 8'h00;
  localparam logic [7:0] LATCH_ARM       = 8'h00;
  localparam logic [7:0] LATCH_FIRE      = 8'h01;
  localparam logic [7:0] BYTE_ALL_ONES   = 8'hFF;

  // address regions, by address bits 15:13
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_ROMBNK = 3'd1;
  localparam logic [2:0] REG_SELECT = 3'd2;
  localparam logic [2:0] REG_LATCH  = 3'd3;
  localparam logic [2:0] REG_VIDEO  = 3'd4;
  localparam logic [2:0] REG_WINDOW = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]            read_data;
    logic                  rom_read;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic                  bad_address;
  } out_item_t;

  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [7:0] day_lo;
    logic [7:0] day_hi;
  } rtc_time_t;

  // requests from the decode to the clock unit
  typedef struct packed {
    logic       tick;
    logic       wr;
    logic       latch;
    logic [7:0] sel;
    logic [7:0] data;
  } rtc_ctl_t;

endpackage

`default_nettype wire

/* design/cbm_ram.sv */
// banked external ram, one write or one registered read per cycle
// depends on cbm_pkg for depth and address width
`default_nettype none

module cbm_ram (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic                         re,
  input  wire logic [cbm_pkg::RAM_ADDR_W-1:0] addr,
  input  wire logic [7:0]                   wdata,
  output logic      [7:0]                   q
);

  logic [7:0] mem [cbm_pkg::RAM_DEPTH];
  logic [7:0] q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      q_r <= mem[addr];
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

/* design/cbm_rtc.sv */
// real-time clock: live and latched copies, tick advance, writes, latch rule
// depends on cbm_pkg for the time and control structs
`default_nettype none

module cbm_rtc (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cbm_pkg::rtc_ctl_t ctl,
  output cbm_pkg::rtc_time_t     rd_time
);

  cbm_pkg::rtc_time_t live_r, live_nxt;
  cbm_pkg::rtc_time_t lat_r, lat_nxt;
  cbm_pkg::rtc_time_t cur;
  cbm_pkg::rtc_time_t wr_time;
  logic [7:0]         last_r, last_nxt;
  logic               use_lat_r, use_lat_nxt;
  logic               sel_clk;

  // v mod 60: v = 4q + r, and 16 = 1 mod 15
  function automatic logic [7:0] mod60(input logic [7:0] v);
    logic [4:0] s;
    s = {3'b000, v[7:6]} + {1'b0, v[5:2]};
    if (s >= 5'd15) begin
      s = s - 5'd15;
    end
    return {2'b00, s[3:0], v[1:0]};
  endfunction

  // v mod 24: v = 8q + r, and 4 = 1 mod 3
  function automatic logic [7:0] mod24(input logic [7:0] v);
    logic [2:0] s;
    s = {2'b00, v[7]} + {1'b0, v[6:5]} + {1'b0, v[4:3]};
    if (s >= 3'd6) begin
      s = s - 3'd6;
    end else if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    return {3'b000, s[1:0], v[2:0]};
  endfunction

  function automatic cbm_pkg::rtc_time_t advance(input cbm_pkg::rtc_time_t t);
    cbm_pkg::rtc_time_t n;
    n = t;
    n.sec = n.sec + 8'd1;
    if (n.sec >= 8'd60) begin
      n.sec = n.sec - 8'd60;
      n.min = n.min + 8'd1;
    end
    if (n.min >= 8'd60) begin
      n.min = n.min - 8'd60;
      n.hour = n.hour + 8'd1;
    end
    if (n.hour >= 8'd24) begin
      n.hour = n.hour - 8'd24;
      n.day_lo = n.day_lo + 8'd1;
      if (n.day_lo == 8'd0) begin
        if (n.day_hi[0]) begin
          n.day_hi = {1'b1, n.day_hi[6:1], 1'b0};
        end else begin
          n.day_hi = {n.day_hi[7:1], 1'b1};
        end
      end
    end
    return n;
  endfunction

  assign cur     = use_lat_r ? lat_r : live_r;
  assign rd_time = cur;
  assign sel_clk = (ctl.sel >= cbm_pkg::SEL_SEC) && (ctl.sel <= cbm_pkg::SEL_DAY_HI);

  always_comb begin
    wr_time = cur;
    unique case (ctl.sel)
      cbm_pkg::SEL_SEC:    wr_time.sec    = mod60(ctl.data);
      cbm_pkg::SEL_MIN:    wr_time.min    = mod60(ctl.data);
      cbm_pkg::SEL_HOUR:   wr_time.hour   = mod24(ctl.data);
      cbm_pkg::SEL_DAY_LO: wr_time.day_lo = ctl.data;
      cbm_pkg::SEL_DAY_HI: wr_time.day_hi = ctl.data;
      default:             wr_time        = cur;
    endcase
  end

  always_comb begin
    live_nxt    = live_r;
    lat_nxt     = lat_r;
    last_nxt    = last_r;
    use_lat_nxt = use_lat_r;
    if (ctl.tick && !live_r.day_hi[6]) begin
      live_nxt = advance(live_r);
    end
    if (ctl.wr) begin
      if (use_lat_r) begin
        lat_nxt = wr_time;
      end else begin
        live_nxt = wr_time;
      end
    end
    if (ctl.latch && sel_clk) begin
      if (last_r == cbm_pkg::LATCH_ARM && ctl.data == cbm_pkg::LATCH_FIRE) begin
        lat_nxt     = live_r;
        use_lat_nxt = 1'b1;
      end else begin
        last_nxt    = ctl.data;
        use_lat_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r    <= '0;
      lat_r     <= '0;
      last_r    <= cbm_pkg::BYTE_ALL_ONES;
      use_lat_r <= 1'b0;
    end else begin
      live_r    <= live_nxt;
      lat_r     <= lat_nxt;
      last_r    <= last_nxt;
      use_lat_r <= use_lat_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/cartridge_bank_mapper_with_rtc_unit.sv */
// top level of the cartridge bank mapper with real-time clock
// depends on cbm_pkg, cbm_ram and cbm_rtc
//
//   channel   ports                              direction  payload
//   request   in_valid, in_stall, in_data        in         in_item_t
//   result    out_valid, out_stall, out_data     out        out_item_t
//   config    cfg_wr_en, cfg_wr_data             in         ram bank count
//
// one request per cycle sustained while out_stall is low; a request passes
// through the request register and then sits in the result register until taken
// the ram read port is registered and its data lands beside the result register
// rst_n is synchronous, resets the control registers and the clock, not the ram
// a stalled result holds the result register and the request register behind
// it; in_stall rises only when both are full
`default_nettype none

module cartridge_bank_mapper_with_rtc_unit (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire cbm_pkg::in_item_t        in_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output cbm_pkg::out_item_t            out_data,
  input  wire logic                     cfg_wr_en,
  input  wire logic [cbm_pkg::CNT_W-1:0] cfg_wr_data
);

  // request register
  logic               a_valid_r, a_valid_nxt;
  cbm_pkg::in_item_t  a_item_r;

  // result register
  logic               out_valid_r, out_valid_nxt;
  cbm_pkg::out_item_t out_r;
  logic               from_ram_r;

  // mapper control registers
  logic [cbm_pkg::CNT_W-1:0]      bank_cnt_r;
  logic                           ram_en_r, ram_en_nxt;
  logic [cbm_pkg::ROM_BANK_W-1:0] rom_bank_r, rom_bank_nxt;
  logic [7:0]                     select_r, select_nxt;

  logic                           adv;
  logic                           accept;
  logic                           is_rd, is_wr, is_tick;
  logic [2:0]                     region;
  logic                           win_on;
  logic [cbm_pkg::CNT_W-1:0]      banks_present;
  logic                           ram_ok;
  logic                           sel_ram;
  cbm_pkg::out_item_t             res;
  logic                           res_from_ram;
  logic [7:0]                     clk_byte;
  logic [cbm_pkg::ROM_BANK_W-1:0] rom_bank;
  logic [cbm_pkg::ROM_BANK_W-1:0] wr_bank;
  logic [cbm_pkg::RAM_SEL_W+cbm_pkg::RAM_OFFS_W-1:0] ram_idx_full;
  logic                           ram_we, ram_re;
  logic [7:0]                     ram_q;
  cbm_pkg::rtc_ctl_t              rtc_ctl;
  cbm_pkg::rtc_time_t             rtc_time;

  // handshake: request moves to the result register when that is free
  assign adv      = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = a_valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  assign a_valid_nxt   = accept ? 1'b1 : (adv ? 1'b0 : a_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  // request decode
  assign is_rd   = a_item_r.req_type == cbm_pkg::REQ_READ;
  assign is_wr   = a_item_r.req_type == cbm_pkg::REQ_WRITE;
  assign is_tick = a_item_r.req_type == cbm_pkg::REQ_TICK;
  assign region  = a_item_r.address[15:13];

  // bank count saturates at the banks that exist
  assign banks_present = (bank_cnt_r > cbm_pkg::CNT_W'(cbm_pkg::RAM_BANK_TOTAL))
                       ? cbm_pkg::CNT_W'(cbm_pkg::RAM_BANK_TOTAL) : bank_cnt_r;
  assign win_on  = ram_en_r && (bank_cnt_r != '0);
  assign sel_ram = select_r <= cbm_pkg::SEL_RAM_LAST;
  assign ram_ok  = sel_ram && (select_r < {{(8-cbm_pkg::CNT_W){1'b0}}, banks_present});

  assign rom_bank = cbm_pkg::ROM_BANK_W'(rom_bank_r % cbm_pkg::ROM_BANK_TOTAL);

  // ram index: bank select above the offset inside the window
  assign ram_idx_full = {select_r[cbm_pkg::RAM_SEL_W-1:0],
                         a_item_r.address[cbm_pkg::RAM_OFFS_W-1:0]};

  // clock register picked by the select code
  always_comb begin
    unique case (select_r)
      cbm_pkg::SEL_SEC:    clk_byte = rtc_time.sec;
      cbm_pkg::SEL_MIN:    clk_byte = rtc_time.min;
      cbm_pkg::SEL_HOUR:   clk_byte = rtc_time.hour;
      cbm_pkg::SEL_DAY_LO: clk_byte = rtc_time.day_lo;
      cbm_pkg::SEL_DAY_HI: clk_byte = rtc_time.day_hi;
      default:             clk_byte = cbm_pkg::BYTE_ALL_ONES;
    endcase
  end

  // result of the request in the request register
  always_comb begin
    res          = '0;
    res_from_ram = 1'b0;
    if (is_rd) begin
      res.read_data = cbm_pkg::BYTE_ALL_ONES;
      if (region == cbm_pkg::REG_ENABLE || region == cbm_pkg::REG_ROMBNK) begin
        // fixed bank zero
        res.rom_read    = 1'b1;
        res.rom_address = {{cbm_pkg::ROM_BANK_W{1'b0}},
                           a_item_r.address[cbm_pkg::ROM_OFFS_W-1:0]};
      end else if (region == cbm_pkg::REG_SELECT || region == cbm_pkg::REG_LATCH) begin
        // switchable bank
        res.rom_read    = 1'b1;
        res.rom_address = {rom_bank, a_item_r.address[cbm_pkg::ROM_OFFS_W-1:0]};
      end else if (region == cbm_pkg::REG_WINDOW) begin
        if (win_on) begin
          if (ram_ok) begin
            res_from_ram = 1'b1;
          end else if (!sel_ram) begin
            res.read_data = clk_byte;
          end
        end
      end else begin
        res.bad_address = 1'b1;
      end
    end else if (is_wr) begin
      if (region == cbm_pkg::REG_VIDEO || region == cbm_pkg::REG_WINDOW + 3'd1
          || region == cbm_pkg::REG_WINDOW + 3'd2) begin
        res.bad_address = 1'b1;
      end
    end
  end

  // control register writes
  assign wr_bank = (a_item_r.write_data[6:0] == '0)
                 ? cbm_pkg::ROM_BANK_W'(1) : a_item_r.write_data[6:0];

  always_comb begin
    ram_en_nxt   = ram_en_r;
    rom_bank_nxt = rom_bank_r;
    select_nxt   = select_r;
    if (adv && is_wr) begin
      unique case (region)
        cbm_pkg::REG_ENABLE: begin
          if (a_item_r.write_data == cbm_pkg::RAM_ENABLE_KEY) begin
            ram_en_nxt = 1'b1;
          end else if (a_item_r.write_data == cbm_pkg::RAM_DISABLE_KEY) begin
            ram_en_nxt = 1'b0;
          end
        end
        cbm_pkg::REG_ROMBNK: rom_bank_nxt = wr_bank;
        cbm_pkg::REG_SELECT: select_nxt   = a_item_r.write_data;
        default:             select_nxt   = select_r;
      endcase
    end
  end

  // ram access happens on the edge the request moves on
  assign ram_we = adv && is_wr && region == cbm_pkg::REG_WINDOW && win_on && ram_ok;
  assign ram_re = adv && res_from_ram;

  cbm_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_idx_full[cbm_pkg::RAM_ADDR_W-1:0]),
    .wdata (a_item_r.write_data),
    .q     (ram_q)
  );

  // clock requests
  always_comb begin
    rtc_ctl       = '0;
    rtc_ctl.sel   = select_r;
    rtc_ctl.data  = a_item_r.write_data;
    rtc_ctl.tick  = adv && is_tick;
    rtc_ctl.wr    = adv && is_wr && region == cbm_pkg::REG_WINDOW && win_on && !sel_ram;
    rtc_ctl.latch = adv && is_wr && region == cbm_pkg::REG_LATCH;
  end

  cbm_rtc u_rtc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (rtc_ctl),
    .rd_time (rtc_time)
  );

  // result port: ram data joins the registered result
  always_comb begin
    out_data = out_r;
    if (from_ram_r) begin
      out_data.read_data = ram_q;
    end
  end
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      bank_cnt_r  <= cbm_pkg::CNT_W'(cbm_pkg::RAM_BANK_TOTAL);
      ram_en_r    <= 1'b0;
      rom_bank_r  <= '0;
      select_r    <= '0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
      ram_en_r    <= ram_en_nxt;
      rom_bank_r  <= rom_bank_nxt;
      select_r    <= select_nxt;
      if (cfg_wr_en) begin
        bank_cnt_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      a_item_r <= in_data;
    end
    if (adv) begin
      out_r      <= res;
      from_ram_r <= res_from_ram;
    end
  end

endmodule

`default_nettype wire
